[rtl/cctlf_pkg.sv]
package cctlf_pkg;

  localparam int unsigned LEVEL_W = 8;
  localparam int unsigned TEMP_W = 7;
  localparam int unsigned DUR_W = 32;
  localparam int unsigned PROD_W = LEVEL_W + DUR_W;
  localparam int unsigned CFG_INDEX_W = 8;
  localparam int unsigned CFG_DATA_W = 8;

  localparam logic [LEVEL_W-1:0] FULL_SCALE = 8'd255;
  localparam logic [TEMP_W-1:0] TEMP_SPLIT = 7'd50;
  localparam logic [TEMP_W-1:0] TEMP_MAX = 7'd100;

  localparam logic [1:0] FUNC_TICK = 2'd0;
  localparam logic [1:0] FUNC_FADE_BOTH = 2'd1;
  localparam logic [1:0] FUNC_FADE_TEMP = 2'd2;
  localparam logic [1:0] FUNC_FADE_LEVEL = 2'd3;

  localparam logic [CFG_INDEX_W-1:0] REG_AUTO_WRITE = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_LAMP_ON = 8'd1;

endpackage

[rtl/cct_lamp_linear_fader.sv]
// A command or an idle tick goes straight to S_DONE; its result is registered once the output is free.
// A tick during a fade runs up to five multiply/divide passes through S_MUL, S_DIV and S_WB
// (shared 8x32 multiplier, 8-step restoring divider).
// One item at a time; a new item is taken while the last result still waits.
// Reset (rst, synchronous): intensity 0, temperature 50, no fade, duties 0,
// auto_write 0, lamp_on 1.
module cct_lamp_linear_fader (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cmd_valid,
  output logic                                cmd_stall,
  input  logic [1:0]                          func,
  input  logic [cctlf_pkg::LEVEL_W-1:0]       target_intensity,
  input  logic [7:0]                          target_cct,
  input  logic [cctlf_pkg::DUR_W-1:0]         duration,
  output logic                                res_valid,
  input  logic                                res_stall,
  output logic [cctlf_pkg::LEVEL_W-1:0]       warm_level,
  output logic [cctlf_pkg::LEVEL_W-1:0]       cool_level,
  output logic [cctlf_pkg::LEVEL_W-1:0]       level_now,
  output logic [cctlf_pkg::TEMP_W-1:0]        temperature_now,
  output logic                                fading,
  output logic                                drive_strobe,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [cctlf_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [cctlf_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int unsigned LW = cctlf_pkg::LEVEL_W;
  localparam int unsigned TW = cctlf_pkg::TEMP_W;
  localparam int unsigned DW = cctlf_pkg::DUR_W;
  localparam int unsigned PW = cctlf_pkg::PROD_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_WB   = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  localparam logic [2:0] OP_LEVEL = 3'd0;
  localparam logic [2:0] OP_TEMP  = 3'd1;
  localparam logic [2:0] OP_BASE  = 3'd2;
  localparam logic [2:0] OP_WARM  = 3'd3;
  localparam logic [2:0] OP_COOL  = 3'd4;

  logic [2:0]    state;
  logic [2:0]    op;
  logic          ending;
  logic          strobe;
  logic          auto_write;
  logic          lamp_on;

  logic [LW-1:0] cur_level;
  logic [TW-1:0] cur_temp;
  logic [LW-1:0] begin_level;
  logic [TW-1:0] begin_temp;
  logic [LW-1:0] goal_level;
  logic [TW-1:0] goal_temp;
  logic [DW-1:0] elapsed_ticks;
  logic [DW-1:0] fade_length;
  logic          active_flag;
  logic [LW-1:0] warm_duty;
  logic [LW-1:0] cool_duty;
  logic [LW-1:0] warm_base;
  logic [LW-1:0] cool_base;

  logic [PW-1:0] rem;
  logic [DW-1:0] divisor;
  logic [2:0]    cnt;
  logic [LW-1:0] quo;

  logic [DW-1:0] t_inc;
  logic [TW-1:0] tgt_temp;
  logic [LW-1:0] span_level;
  logic [TW-1:0] span_temp;
  logic          temp_low;
  logic [LW-1:0] mul_a;
  logic [DW-1:0] mul_b;
  logic [DW-1:0] div_d;
  logic [PW-1:0] prod;
  logic [PW-1:0] trial;
  logic          trial_ge;
  logic [LW-1:0] quo_next;
  logic [LW-1:0] level_up;
  logic [LW-1:0] level_dn;
  logic [LW-1:0] temp_sum;
  logic [TW-1:0] temp_next;
  logic          res_free;

  assign cmd_stall = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign res_free  = !res_valid || !res_stall;

  assign t_inc = (elapsed_ticks == '1) ? elapsed_ticks : elapsed_ticks + DW'(1);
  assign tgt_temp = (target_cct > {1'b0, cctlf_pkg::TEMP_MAX}) ? cctlf_pkg::TEMP_MAX
                                                               : target_cct[TW-1:0];
  assign span_level = (goal_level >= begin_level) ? goal_level - begin_level
                                                  : begin_level - goal_level;
  assign span_temp  = (goal_temp >= begin_temp) ? goal_temp - begin_temp
                                                 : begin_temp - goal_temp;
  assign temp_low = (cur_temp <= cctlf_pkg::TEMP_SPLIT);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    div_d = DW'(cctlf_pkg::FULL_SCALE);
    case (op)
      OP_LEVEL: begin
        mul_a = span_level;
        mul_b = elapsed_ticks;
        div_d = fade_length;
      end
      OP_TEMP: begin
        mul_a = LW'(span_temp);
        mul_b = elapsed_ticks;
        div_d = fade_length;
      end
      OP_BASE: begin
        mul_a = temp_low ? LW'(cur_temp) : LW'(cur_temp - cctlf_pkg::TEMP_SPLIT);
        mul_b = DW'(cctlf_pkg::FULL_SCALE);
        div_d = DW'(cctlf_pkg::TEMP_MAX - cctlf_pkg::TEMP_SPLIT);
      end
      OP_WARM: begin
        mul_a = warm_base;
        mul_b = DW'(cur_level);
      end
      OP_COOL: begin
        mul_a = cool_base;
        mul_b = DW'(cur_level);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod     = PW'(mul_a) * PW'(mul_b);
  assign trial    = PW'(divisor) << cnt;
  assign trial_ge = (rem >= trial);
  assign quo_next = {quo[LW-2:0], trial_ge};

  assign level_up  = begin_level + quo;
  assign level_dn  = begin_level - quo;
  assign temp_sum  = (goal_temp >= begin_temp) ? LW'(begin_temp) + quo
                                               : LW'(begin_temp) - quo;
  assign temp_next = (temp_sum > LW'(cctlf_pkg::TEMP_MAX)) ? cctlf_pkg::TEMP_MAX
                                                           : temp_sum[TW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      op            <= OP_LEVEL;
      ending        <= 1'b0;
      strobe        <= 1'b0;
      auto_write    <= 1'b0;
      lamp_on       <= 1'b1;
      cur_level     <= '0;
      cur_temp      <= cctlf_pkg::TEMP_SPLIT;
      begin_level   <= '0;
      begin_temp    <= cctlf_pkg::TEMP_SPLIT;
      goal_level    <= '0;
      goal_temp     <= cctlf_pkg::TEMP_SPLIT;
      elapsed_ticks <= '0;
      fade_length   <= '0;
      active_flag   <= 1'b0;
      warm_duty     <= '0;
      cool_duty     <= '0;
      res_valid     <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == cctlf_pkg::REG_AUTO_WRITE) begin
          auto_write <= cfg_data[0];
        end else if (cfg_index == cctlf_pkg::REG_LAMP_ON) begin
          lamp_on <= cfg_data[0];
        end
      end
      if (res_valid && !res_stall && state != S_DONE) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            if (func == cctlf_pkg::FUNC_TICK) begin
              strobe <= active_flag && auto_write;
              state  <= active_flag ? S_MUL : S_DONE;
              if (active_flag) begin
                elapsed_ticks <= t_inc;
                ending        <= !(t_inc < fade_length);
                op            <= (t_inc < fade_length) ? OP_LEVEL : OP_BASE;
              end else if (!lamp_on) begin
                cur_level <= '0;
              end
            end else begin
              strobe        <= 1'b0;
              state         <= S_DONE;
              active_flag   <= 1'b1;
              elapsed_ticks <= '0;
              fade_length   <= duration;
              begin_level   <= cur_level;
              begin_temp    <= cur_temp;
              if (func != cctlf_pkg::FUNC_FADE_TEMP) begin
                goal_level <= target_intensity;
              end
              if (func != cctlf_pkg::FUNC_FADE_LEVEL) begin
                goal_temp <= tgt_temp;
              end
            end
          end
        end
        S_MUL: begin
          if (op == OP_LEVEL && goal_level == cur_level) begin
            op <= OP_TEMP;
          end else if (op == OP_TEMP && goal_temp == cur_temp) begin
            op <= OP_BASE;
          end else begin
            rem     <= prod;
            divisor <= div_d;
            cnt     <= 3'(LW - 1);
            state   <= S_DIV;
          end
        end
        S_DIV: begin
          if (trial_ge) begin
            rem <= rem - trial;
          end
          quo <= quo_next;
          cnt <= cnt - 3'd1;
          if (cnt == '0) begin
            state <= S_WB;
          end
        end
        S_WB: begin
          case (op)
            OP_LEVEL: begin
              cur_level <= (goal_level >= begin_level) ? level_up : level_dn;
              op        <= OP_TEMP;
              state     <= S_MUL;
            end
            OP_TEMP: begin
              cur_temp <= temp_next;
              op       <= OP_BASE;
              state    <= S_MUL;
            end
            OP_BASE: begin
              warm_base <= temp_low ? cctlf_pkg::FULL_SCALE : cctlf_pkg::FULL_SCALE - quo;
              cool_base <= temp_low ? quo : cctlf_pkg::FULL_SCALE;
              op        <= OP_WARM;
              state     <= S_MUL;
            end
            OP_WARM: begin
              warm_duty <= quo;
              op        <= OP_COOL;
              state     <= S_MUL;
            end
            OP_COOL: begin
              cool_duty <= quo;
              state     <= S_DONE;
              if (ending) begin
                cur_level   <= lamp_on ? goal_level : '0;
                cur_temp    <= goal_temp;
                active_flag <= 1'b0;
              end
            end
            default: begin
              state <= S_DONE;
            end
          endcase
        end
        S_DONE: begin
          if (res_free) begin
            res_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && res_free) begin
      warm_level      <= warm_duty;
      cool_level      <= cool_duty;
      level_now       <= cur_level;
      temperature_now <= cur_temp;
      fading          <= active_flag;
      drive_strobe    <= strobe;
    end
  end

  a_temp_range: assert property (@(posedge clk) disable iff (rst)
    cur_temp <= cctlf_pkg::TEMP_MAX)
    else $error("temperature out of range");

  a_elapsed_bound: assert property (@(posedge clk) disable iff (rst)
    active_flag && state == S_IDLE |-> elapsed_ticks <= fade_length)
    else $error("fade still active past its length");

  a_quo_fits: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV && cnt == 3'(LW - 1) |-> rem < (PW'(divisor) << LW))
    else $error("quotient overflows the divider");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && !cmd_stall |=> cmd_stall)
    else $error("item accepted without going busy");

  a_strobe_only_tick: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && !cmd_stall && func != cctlf_pkg::FUNC_TICK |=> !strobe)
    else $error("drive strobe raised on a command");

endmodule
